// ----- rtl/text_console_glyph_renderer_core_defines.svh -----
// Assertion macros used by the renderer back end (tcgr_back).
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define TCGR_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TCGR_ASSERT_NEVER(label, ck, rn, cond, msg) \
    `TCGR_ASSERT(label, ck, rn, !(cond), msg)

`else

`define TCGR_ASSERT(label, ck, rn, prop, msg)

`define TCGR_ASSERT_NEVER(label, ck, rn, cond, msg)

`endif

`endif

// ----- rtl/tcgr_pkg.sv -----
package tcgr_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TEXT_COLUMNS = 3'd1;
    localparam logic [2:0] REG_TEXT_ROWS    = 3'd2;
    localparam logic [2:0] REG_BOLD_ENABLE  = 3'd3;
    localparam logic [2:0] REG_YELLOW_COLOR = 3'd4;

    // Register reset values
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [8:0]  TEXT_COLUMNS_RST = 9'd80;
    localparam logic [7:0]  TEXT_ROWS_RST    = 8'd30;
    localparam logic        BOLD_ENABLE_RST  = 1'b0;
    localparam logic [31:0] YELLOW_COLOR_RST = 32'h00AA5500;

    // Console byte codes
    localparam logic [7:0] ESC_CODE       = 8'h1B;
    localparam logic [7:0] CR_CODE        = 8'h0D;
    localparam logic [7:0] LF_CODE        = 8'h0A;
    localparam logic [7:0] TAB_CODE       = 8'h09;
    localparam logic [7:0] UPPER_A_CODE   = 8'h41;
    localparam logic [7:0] UPPER_Z_CODE   = 8'h5A;
    localparam logic [7:0] LOWER_A_CODE   = 8'h61;
    localparam logic [7:0] LOWER_Z_CODE   = 8'h7A;

    // Colour constants for bold rendering
    localparam logic [7:0]  BRIGHT_STEP = 8'h55;
    localparam logic [7:0]  BYTE_MAX    = 8'hFF;
    localparam logic [31:0] BOLD_YELLOW = 32'h00FFFF55;

    // Cursor limits
    localparam logic [8:0] CURSOR_COL_MAX  = 9'd511;
    localparam logic [7:0] CURSOR_LINE_MAX = 8'd255;
    localparam logic [9:0] TAB_STEP        = 10'd4;

    // Input operation and result kind codes
    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_LOAD     = 1'b1;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    typedef enum logic [1:0] {
        CMD_DRAW,
        CMD_SCROLL,
        CMD_LOAD
    } cmd_kind_t;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [8:0]  text_columns;
        logic [7:0]  text_rows;
        logic        bold_enable;
        logic [31:0] yellow_color;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  char_code;
        logic [7:0]  cell_column;
        logic [6:0]  cell_row;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [3:0]  font_row;
        logic [7:0]  font_bits;
    } in_item_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  char_code;
        logic [7:0]  cell_column;
        logic [6:0]  cell_row;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [3:0]  font_row;
        logic [7:0]  font_bits;
        logic        scroll;
        logic        blank;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [21:0] pixel_index;
        logic [31:0] left_pixel;
        logic [31:0] right_pixel;
        logic        scroll_request;
        logic        last;
    } res_t;

endpackage

// ----- rtl/tcgr_front.sv -----
module tcgr_front
    import tcgr_pkg::*;
#(
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_COUNT  = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic [8:0] col_reg, col_next;
    logic [7:0] line_reg, line_next;
    logic       esc_reg, esc_next;
    logic       has_cmd;
    logic       do_wrap;
    logic       scroll;
    logic [9:0] tab_sum;
    logic       in_fire;

    // Brighten each byte with saturation, yellow maps to a fixed colour
    function automatic logic [31:0] brighten(input logic [31:0] c, input logic [31:0] yellow);
        logic [31:0] r;
        logic [8:0]  b;
        r = '0;
        if (c == yellow) begin
            r = BOLD_YELLOW;
        end
        else begin
            for (int k = 0; k < 4; k++) begin
                b = {1'b0, c[8*k +: 8]} + {1'b0, BRIGHT_STEP};
                r[8*k +: 8] = b[8] ? BYTE_MAX : b[7:0];
            end
        end
        return r;
    endfunction

    assign in_ready = cmd_ready;
    assign in_fire  = in_valid && in_ready;
    assign tab_sum  = {1'b0, col_reg} + TAB_STEP;

    // Classify the byte and work out the cursor
    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        esc_next  = esc_reg;
        has_cmd   = 1'b0;
        do_wrap   = 1'b0;
        scroll    = 1'b0;

        cmd.kind        = CMD_DRAW;
        cmd.char_code   = in_item.char_code;
        cmd.cell_column = in_item.cell_column;
        cmd.cell_row    = in_item.cell_row;
        cmd.fg_color    = cfg.bold_enable ? brighten(in_item.fg_color, cfg.yellow_color)
                                          : in_item.fg_color;
        cmd.bg_color    = in_item.bg_color;
        cmd.font_row    = in_item.font_row;
        cmd.font_bits   = in_item.font_bits;
        cmd.blank       = !({1'b0, in_item.char_code} < 9'(GLYPH_COUNT));

        if (in_item.operation == OP_LOAD) begin
            cmd.kind = CMD_LOAD;
            has_cmd  = !cmd.blank && (5'(in_item.font_row) < 5'(GLYPH_HEIGHT));
        end
        else if (in_item.char_code == ESC_CODE) begin
            esc_next = 1'b1;
        end
        else if (esc_reg) begin
            if (in_item.char_code inside {[UPPER_A_CODE:UPPER_Z_CODE],
                                          [LOWER_A_CODE:LOWER_Z_CODE]}) begin
                esc_next = 1'b0;
            end
        end
        else begin
            case (in_item.char_code)
                CR_CODE:
                begin
                    col_next = '0;
                end
                LF_CODE:
                begin
                    if (line_next != CURSOR_LINE_MAX) begin
                        line_next = line_next + 8'd1;
                    end
                    do_wrap  = 1'b1;
                    cmd.kind = CMD_SCROLL;
                end
                TAB_CODE:
                begin
                    col_next = (tab_sum > {1'b0, CURSOR_COL_MAX}) ? CURSOR_COL_MAX
                                                                  : tab_sum[8:0];
                end
                default:
                begin
                    if (col_next != CURSOR_COL_MAX) begin
                        col_next = col_next + 9'd1;
                    end
                    do_wrap  = 1'b1;
                    has_cmd  = 1'b1;
                    cmd.kind = CMD_DRAW;
                end
            endcase
        end

        // Wrap the column; when off the screen, step back a line and request a scroll
        if (do_wrap) begin
            if (col_next >= cfg.text_columns) begin
                col_next = '0;
                if (line_next != CURSOR_LINE_MAX) begin
                    line_next = line_next + 8'd1;
                end
            end
            if (line_next >= cfg.text_rows) begin
                if (line_next != 8'd0) begin
                    line_next = line_next - 8'd1;
                end
                scroll = 1'b1;
            end
        end

        if (cmd.kind == CMD_SCROLL) begin
            has_cmd = scroll;
        end
        cmd.scroll = scroll;
    end

    assign cmd_valid = in_valid && has_cmd;

    // Hold the cursor and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg  <= '0;
            line_reg <= '0;
            esc_reg  <= 1'b0;
        end
        else if (in_fire) begin
            col_reg  <= col_next;
            line_reg <= line_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

// ----- rtl/tcgr_queue.sv -----
module tcgr_queue
    import tcgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_data
);

    cmd_t       entry_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= in_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/tcgr_back.sv -----
`include "text_console_glyph_renderer_core_defines.svh"

module tcgr_back
    import tcgr_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 2048,
    parameter int GLYPH_HEIGHT    = 16,
    parameter int GLYPH_COUNT     = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_HEIGHT);
    localparam int SW    = $clog2(MAX_FRAME_WIDTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PRIME,
        ST_EMIT
    } state_t;

    logic [7:0]    store_mem [DEPTH];
    logic [7:0]    rd_data_reg;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [RW-1:0] row_reg;
    logic [1:0]    pair_reg;
    logic [7:0]    bits_reg;
    logic [21:0]   line_reg;
    logic          res_valid_reg;
    res_t          res_reg;

    logic          slot_free;
    logic          pop;
    logic          res_load;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] glyph_base;
    logic          last_row;
    logic          more_rows;
    logic [SW-1:0] stride;
    logic [21:0]   line_start;
    res_t          pair_res;
    res_t          scroll_res;

    assign slot_free  = !res_valid_reg || res_ready;
    assign cmd_ready  = (state_reg == ST_IDLE) && ((cmd.kind != CMD_SCROLL) || slot_free);
    assign pop        = cmd_valid && cmd_ready;
    assign res_load   = ((state_reg == ST_IDLE) && pop && (cmd.kind == CMD_SCROLL))
                     || ((state_reg == ST_EMIT) && slot_free);
    assign wr_en      = pop && (cmd.kind == CMD_LOAD);
    assign wr_addr    = AW'(32'(cmd.char_code) * 32'(GLYPH_HEIGHT) + 32'(cmd.font_row));
    assign glyph_base = AW'(32'(cmd_reg.char_code) * 32'(GLYPH_HEIGHT));
    assign last_row   = (32'(row_reg) == 32'(GLYPH_HEIGHT - 1));
    assign more_rows  = (32'(row_reg) + 32'd2 < 32'(GLYPH_HEIGHT));

    // Clamp the line stride
    assign stride = (13'(cfg.frame_width) > 13'(MAX_FRAME_WIDTH)) ? SW'(MAX_FRAME_WIDTH)
                                                                  : SW'(cfg.frame_width);

    // Index of the top-left pixel of the cell
    assign line_start = 22'(cmd_reg.cell_row) * 22'(GLYPH_HEIGHT) * 22'(stride)
                      + 22'({cmd_reg.cell_column, 3'b000});

    // Prefetch glyph rows one ahead of the row being drawn
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = glyph_base;
        case (state_reg)
            ST_FETCH:
            begin
                rd_en = !cmd_reg.blank;
            end
            ST_PRIME:
            begin
                rd_en   = !cmd_reg.blank;
                rd_addr = glyph_base + AW'(1);
            end
            ST_EMIT:
            begin
                rd_en   = slot_free && (pair_reg == 2'd3) && more_rows && !cmd_reg.blank;
                rd_addr = glyph_base + AW'(row_reg) + AW'(2);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Build the pixel pair and scroll-only results
    always_comb
    begin
        pair_res.kind           = KIND_PIXEL;
        pair_res.pixel_index    = line_reg + 22'({pair_reg, 1'b0});
        pair_res.left_pixel     = bits_reg[{~pair_reg, 1'b1}] ? cmd_reg.fg_color
                                                              : cmd_reg.bg_color;
        pair_res.right_pixel    = bits_reg[{~pair_reg, 1'b0}] ? cmd_reg.fg_color
                                                              : cmd_reg.bg_color;
        pair_res.last           = last_row && (pair_reg == 2'd3);
        pair_res.scroll_request = pair_res.last && cmd_reg.scroll;

        scroll_res.kind           = KIND_SCROLL;
        scroll_res.pixel_index    = '0;
        scroll_res.left_pixel     = '0;
        scroll_res.right_pixel    = '0;
        scroll_res.scroll_request = 1'b1;
        scroll_res.last           = 1'b1;
    end

    // Glyph store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            store_mem[wr_addr] <= cmd.font_bits;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Sequence commands and drive the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else begin
            // Raise valid on a new result, drop it once the beat is taken
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop) begin
                        case (cmd.kind)
                            CMD_DRAW:
                            begin
                                cmd_reg   <= cmd;
                                state_reg <= ST_FETCH;
                            end
                            CMD_SCROLL:
                            begin
                                res_reg <= scroll_res;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FETCH:
                begin
                    line_reg  <= line_start;
                    state_reg <= ST_PRIME;
                end
                ST_PRIME:
                begin
                    bits_reg  <= cmd_reg.blank ? 8'd0 : rd_data_reg;
                    row_reg   <= '0;
                    pair_reg  <= 2'd0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free) begin
                        res_reg  <= pair_res;
                        pair_reg <= pair_reg + 2'd1;
                        if (pair_reg == 2'd3) begin
                            if (last_row) begin
                                state_reg <= ST_IDLE;
                            end
                            else begin
                                row_reg  <= row_reg + RW'(1);
                                bits_reg <= cmd_reg.blank ? 8'd0 : rd_data_reg;
                                line_reg <= line_reg + 22'(stride);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `TCGR_ASSERT(a_scroll_only_zero, clk, rst_n, res_valid_reg && (res_reg.kind == KIND_SCROLL) |-> (res_reg.pixel_index == '0) && (res_reg.left_pixel == '0) && (res_reg.right_pixel == '0) && res_reg.scroll_request && res_reg.last, "scroll-only result carries pixel data")
    `TCGR_ASSERT_NEVER(a_write_while_drawing, clk, rst_n, wr_en && (rd_en || (state_reg != ST_IDLE)), "glyph store written during a draw")
    `TCGR_ASSERT(a_read_in_range, clk, rst_n, rd_en |-> (32'(rd_addr) < 32'(DEPTH)), "glyph store read out of range")
    `TCGR_ASSERT(a_draw_ends_idle, clk, rst_n, (state_reg == ST_EMIT) && slot_free && (pair_reg == 2'd3) && last_row |=> (state_reg == ST_IDLE) && res_valid_reg && res_reg.last, "draw did not close on its last pair")

endmodule

// ----- rtl/text_console_glyph_renderer_core.sv -----
// Channel  | Dir | Signals                         | Beat contents
// ---------+-----+---------------------------------+--------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata s_tuser | one console byte or one font row
// m_       | out | m_tvalid m_tready m_tdata m_tuser m_tlast | one pixel pair or scroll request
// apb      | in  | psel penable pwrite paddr pwdata prdata pready | register access
//
// A printable byte holds the back end to take the command and fetch the first glyph row
// (FETCH, PRIME), then 64 result-register pairs, one pixel pair per cycle unless m_ stalls.
// The back end handles font loads and scroll-only results in IDLE; other bytes end in front.
// A two-entry command queue lets the front keep taking beats while the back end draws.
// Reset clears cursor, escape state, queue and output valid; the glyph store is not cleared.
// A stalled m_ channel holds the back end; the front stalls only when the queue fills.
module text_console_glyph_renderer_core
    import tcgr_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 2048,
    parameter int GLYPH_HEIGHT    = 16,
    parameter int GLYPH_COUNT     = 256
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // char_code[7:0], cell_column[15:8], cell_row[22:16], fg_color[54:23],
    // bg_color[86:55], font_row[90:87], font_bits[98:91], zero pad[103:99]
    input  logic [103:0] s_tdata,
    // operation[0]
    input  logic [0:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_index[21:0], left_pixel[53:22], right_pixel[85:54],
    // scroll_request[86], zero pad[87]
    output logic [87:0]  m_tdata,
    // kind[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       cfg_write;
    in_item_t   in_item;
    logic       fe_valid;
    logic       fe_ready;
    cmd_t       fe_cmd;
    logic       be_valid;
    logic       be_ready;
    cmd_t       be_cmd;
    res_t       res;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.text_columns <= TEXT_COLUMNS_RST;
            cfg_reg.text_rows    <= TEXT_ROWS_RST;
            cfg_reg.bold_enable  <= BOLD_ENABLE_RST;
            cfg_reg.yellow_color <= YELLOW_COLOR_RST;
        end
        else if (cfg_write) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[11:0];
                REG_TEXT_COLUMNS: cfg_reg.text_columns <= pwdata[8:0];
                REG_TEXT_ROWS:    cfg_reg.text_rows    <= pwdata[7:0];
                REG_BOLD_ENABLE:  cfg_reg.bold_enable  <= pwdata[0];
                REG_YELLOW_COLOR: cfg_reg.yellow_color <= pwdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            REG_TEXT_COLUMNS: prdata = 32'(cfg_reg.text_columns);
            REG_TEXT_ROWS:    prdata = 32'(cfg_reg.text_rows);
            REG_BOLD_ENABLE:  prdata = 32'(cfg_reg.bold_enable);
            REG_YELLOW_COLOR: prdata = cfg_reg.yellow_color;
            default:          prdata = '0;
        endcase
    end

    // Unpack the input beat
    assign in_item.operation   = s_tuser[0];
    assign in_item.char_code   = s_tdata[7:0];
    assign in_item.cell_column = s_tdata[15:8];
    assign in_item.cell_row    = s_tdata[22:16];
    assign in_item.fg_color    = s_tdata[54:23];
    assign in_item.bg_color    = s_tdata[86:55];
    assign in_item.font_row    = s_tdata[90:87];
    assign in_item.font_bits   = s_tdata[98:91];

    tcgr_front #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_COUNT  (GLYPH_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd)
    );

    tcgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_cmd),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_data  (be_cmd)
    );

    tcgr_back #(
        .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
        .GLYPH_HEIGHT    (GLYPH_HEIGHT),
        .GLYPH_COUNT     (GLYPH_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (be_valid),
        .cmd_ready (be_ready),
        .cmd       (be_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the output beat
    assign m_tdata = {1'b0, res.scroll_request, res.right_pixel, res.left_pixel,
                      res.pixel_index};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ----- verif/text_console_glyph_renderer_core_tb.sv -----
module text_console_glyph_renderer_core_tb;
    import tcgr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GLYPH_ROWS     = 16;
    localparam int STRIDE_CAP     = 2048;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_CYCLES    = 200;
    localparam int CYCLE_LIMIT    = 400000;

    // Bytes of a well-formed escape sequence
    localparam logic [7:0] CSI_OPEN   = 8'h5B;
    localparam logic [7:0] PARAM_SEP  = 8'h3B;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    // The two glyphs loaded in full; only these codes are drawn
    localparam logic [7:0] GLYPH_LOW  = 8'h00;
    localparam logic [7:0] GLYPH_HIGH = 8'hFF;

    // Tracks cursor, escape state, glyph store and registers; holds the pixel
    // pairs and scroll requests that the renderer still owes.
    class console_scoreboard;
        logic [11:0] frame_width;
        logic [8:0]  text_columns;
        logic [7:0]  text_rows;
        logic        bold;
        logic [31:0] yellow;
        int unsigned cur_col;
        int unsigned cur_line;
        bit          in_escape;
        logic [7:0]  glyph_rows [0:GLYPH_ROWS*256-1];
        res_t        pending_pairs [$];
        int unsigned mismatches;
        int unsigned drawn;
        int unsigned scrolls;
        int unsigned loads;
        int unsigned quiet;

        function new();
            frame_width  = FRAME_WIDTH_RST;
            text_columns = TEXT_COLUMNS_RST;
            text_rows    = TEXT_ROWS_RST;
            bold         = BOLD_ENABLE_RST;
            yellow       = YELLOW_COLOR_RST;
            cur_col      = 0;
            cur_line     = 0;
            in_escape    = 1'b0;
            mismatches   = 0;
            drawn        = 0;
            scrolls      = 0;
            loads        = 0;
            quiet        = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_FRAME_WIDTH:  frame_width  = val[11:0];
                REG_TEXT_COLUMNS: text_columns = val[8:0];
                REG_TEXT_ROWS:    text_rows    = val[7:0];
                REG_BOLD_ENABLE:  bold         = val[0];
                REG_YELLOW_COLOR: yellow       = val;
                default: ;
            endcase
        endfunction

        // Brighten each byte with saturation; the yellow colour maps to a fixed one
        function logic [31:0] brighten(logic [31:0] c);
            logic [31:0] r;
            logic [8:0]  b;
            int          k;
            if (c == yellow)
                return BOLD_YELLOW;
            for (k = 0; k < 4; k++)
            begin
                b = {1'b0, c[8*k +: 8]} + {1'b0, BRIGHT_STEP};
                r[8*k +: 8] = b[8] ? BYTE_MAX : b[7:0];
            end
            return r;
        endfunction

        // Wrap the column onto the next line, then step back when off the screen
        function bit wrap_check();
            if (cur_col >= text_columns)
            begin
                cur_col = 0;
                if (cur_line < CURSOR_LINE_MAX)
                    cur_line++;
            end
            if (cur_line >= text_rows)
            begin
                if (cur_line > 0)
                    cur_line--;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void queue_result(logic kind, logic [21:0] idx, logic [31:0] lp,
                                   logic [31:0] rp, logic scr, logic fin);
            res_t r;
            r.kind           = kind;
            r.pixel_index    = idx;
            r.left_pixel     = lp;
            r.right_pixel    = rp;
            r.scroll_request = scr;
            r.last           = fin;
            pending_pairs.push_back(r);
        endfunction

        // Advance the console state by one accepted input beat
        function void note_beat(in_item_t it);
            logic [31:0] fg;
            logic [7:0]  bits;
            logic [7:0]  ch;
            int unsigned stride;
            int unsigned base;
            int          r;
            int          p;
            bit          scroll;
            bit          fin;
            ch = it.char_code;
            if (it.operation == OP_LOAD)
            begin
                glyph_rows[{it.char_code, it.font_row}] = it.font_bits;
                loads++;
                return;
            end
            if (ch == ESC_CODE)
            begin
                in_escape = 1'b1;
                quiet++;
                return;
            end
            if (in_escape)
            begin
                if ((ch >= UPPER_A_CODE && ch <= UPPER_Z_CODE) ||
                    (ch >= LOWER_A_CODE && ch <= LOWER_Z_CODE))
                    in_escape = 1'b0;
                quiet++;
                return;
            end
            if (ch == CR_CODE)
            begin
                cur_col = 0;
                quiet++;
                return;
            end
            if (ch == LF_CODE)
            begin
                if (cur_line < CURSOR_LINE_MAX)
                    cur_line++;
                if (wrap_check())
                begin
                    queue_result(KIND_SCROLL, '0, '0, '0, 1'b1, 1'b1);
                    scrolls++;
                end
                else
                    quiet++;
                return;
            end
            if (ch == TAB_CODE)
            begin
                cur_col = (cur_col + TAB_STEP > CURSOR_COL_MAX) ? CURSOR_COL_MAX
                                                                : cur_col + TAB_STEP;
                quiet++;
                return;
            end

            // Printable: advance the cursor first, the scroll flag rides on the last pair
            fg      = bold ? brighten(it.fg_color) : it.fg_color;
            stride  = (frame_width > STRIDE_CAP) ? STRIDE_CAP : frame_width;
            cur_col = (cur_col + 1 > CURSOR_COL_MAX) ? CURSOR_COL_MAX : cur_col + 1;
            scroll  = wrap_check();
            for (r = 0; r < GLYPH_ROWS; r++)
            begin
                bits = glyph_rows[{ch, 4'(r)}];
                base = (int'(it.cell_row) * GLYPH_ROWS + r) * stride + int'(it.cell_column) * 8;
                for (p = 0; p < 4; p++)
                begin
                    fin = (r == GLYPH_ROWS - 1) && (p == 3);
                    queue_result(KIND_PIXEL, 22'(base + 2 * p),
                                 bits[7 - 2*p] ? fg : it.bg_color,
                                 bits[6 - 2*p] ? fg : it.bg_color,
                                 fin && scroll, fin);
                end
            end
            drawn++;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one output beat with the oldest owed result
        function void check_beat(res_t got);
            res_t want;
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected output beat: kind %0d index %h", got.kind, got.pixel_index);
                mismatches++;
                return;
            end
            want = pending_pairs.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("pixel_index", want.pixel_index, got.pixel_index);
            check_field("left_pixel", want.left_pixel, got.left_pixel);
            check_field("right_pixel", want.right_pixel, got.right_pixel);
            check_field("scroll_request", want.scroll_request, got.scroll_request);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    console_scoreboard board;
    bit                calm;
    bit                long_hold_req;
    int unsigned       settings_used;
    int unsigned       cycle_count;

    text_console_glyph_renderer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // End the run as failed if it reaches the cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Output side: check every beat, stall at random or for a long hold-off
    initial
    begin : result_sink
        int unsigned holdoff;
        res_t        got;
        holdoff = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.kind           = m_tuser[0];
                got.pixel_index    = m_tdata[21:0];
                got.left_pixel     = m_tdata[53:22];
                got.right_pixel    = m_tdata[85:54];
                got.scroll_request = m_tdata[86];
                got.last           = m_tlast;
                board.check_beat(got);
            end
            if (long_hold_req)
            begin
                holdoff       = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (holdoff > 0)
            begin
                holdoff--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 6);
        end
    end

    function automatic in_item_t scatter_item();
        in_item_t it;
        it.operation   = OP_CHAR;
        it.char_code   = 8'($urandom_range(255));
        it.cell_column = 8'($urandom_range(255));
        it.cell_row    = 7'($urandom_range(127));
        it.fg_color    = $urandom();
        it.bg_color    = $urandom();
        it.font_row    = 4'($urandom_range(15));
        it.font_bits   = 8'($urandom_range(255));
        return it;
    endfunction

    // Pick one of the fully loaded glyphs
    function automatic logic [7:0] pick_glyph();
        return ($urandom_range(1) != 0) ? GLYPH_HIGH : GLYPH_LOW;
    endfunction

    // Offer one input beat, with random gaps ahead of it unless calm is set
    task automatic send_beat(input in_item_t it);
        if (!calm)
            while ($urandom_range(99) < 6)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.font_bits, it.font_row, it.bg_color, it.fg_color,
                     it.cell_row, it.cell_column, it.char_code};
        s_tuser  <= it.operation;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_beat(it);
    endtask

    task automatic send_char(input logic [7:0] ch);
        in_item_t it;
        it           = scatter_item();
        it.char_code = ch;
        send_beat(it);
    endtask

    task automatic send_glyph(input logic [7:0] ch, input logic [7:0] col,
                              input logic [6:0] row, input logic [31:0] fg,
                              input logic [31:0] bg);
        in_item_t it;
        it             = scatter_item();
        it.char_code   = ch;
        it.cell_column = col;
        it.cell_row    = row;
        it.fg_color    = fg;
        it.bg_color    = bg;
        send_beat(it);
    endtask

    task automatic send_load(input logic [7:0] glyph, input logic [3:0] row,
                             input logic [7:0] bits);
        in_item_t it;
        it           = scatter_item();
        it.operation = OP_LOAD;
        it.char_code = glyph;
        it.font_row  = row;
        it.font_bits = bits;
        send_beat(it);
    endtask

    // Hold the input side until every owed result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Idle the block, then load a full register setting
    task automatic apply_setting(input logic [11:0] fw, input logic [8:0] cols,
                                 input logic [7:0] rows, input logic bold,
                                 input logic [31:0] yel);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_FRAME_WIDTH, 32'(fw));
        write_reg(REG_TEXT_COLUMNS, 32'(cols));
        write_reg(REG_TEXT_ROWS, 32'(rows));
        write_reg(REG_BOLD_ENABLE, 32'(bold));
        write_reg(REG_YELLOW_COLOR, yel);
        settings_used++;
    endtask

    // Mostly glyph draws, with cursor moves, font loads and escape sequences
    task automatic random_burst(input int count);
        in_item_t it;
        int       sent;
        int       pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            it   = scatter_item();
            if (pick < 55)
            begin
                it.char_code = pick_glyph();
                case ($urandom_range(9))
                    0: it.fg_color = board.yellow;
                    1: it.fg_color = '0;
                    2: it.fg_color = '1;
                    default: ;
                endcase
                send_beat(it);
            end
            else if (pick < 65)
            begin
                it.operation = OP_LOAD;
                send_beat(it);
            end
            else if (pick < 75)
                send_char(LF_CODE);
            else if (pick < 80)
                send_char(CR_CODE);
            else if (pick < 85)
                send_char(TAB_CODE);
            else if (pick < 95)
            begin
                send_char(ESC_CODE);
                send_char(CSI_OPEN);
                repeat ($urandom_range(1, 3)) send_char(8'(DIGIT_ZERO + $urandom_range(9)));
                send_char(PARAM_SEP);
                repeat ($urandom_range(1, 2)) send_char(8'(DIGIT_ZERO + $urandom_range(9)));
                if ($urandom_range(1))
                    send_char(8'(UPPER_A_CODE + $urandom_range(25)));
                else
                    send_char(8'(LOWER_A_CODE + $urandom_range(25)));
            end
            else
            begin
                // broken sequence: escape followed by bytes that never close it
                send_char(ESC_CODE);
                repeat ($urandom_range(1, 3))
                    send_char(($urandom_range(1) != 0) ? pick_glyph()
                                                       : 8'(DIGIT_ZERO + $urandom_range(9)));
            end
            sent++;
        end
    endtask

    initial
    begin : stimulus
        int g;
        int r;
        board         = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        settings_used = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every row of the two glyphs that get drawn
        calm = 1'b1;
        for (g = 0; g < 2; g++)
            for (r = 0; r < GLYPH_ROWS; r++)
                send_load((g != 0) ? GLYPH_HIGH : GLYPH_LOW, 4'(r), 8'($urandom_range(255)));
        calm = 1'b0;

        // Directed: field extremes, control bytes and escape handling
        apply_setting(FRAME_WIDTH_RST, TEXT_COLUMNS_RST, TEXT_ROWS_RST, 1'b0,
                      YELLOW_COLOR_RST);
        send_load(GLYPH_LOW, 4'd0, 8'h00);
        send_load(GLYPH_LOW, 4'd15, 8'hFF);
        send_glyph(GLYPH_LOW, 8'd0, 7'd0, 32'h0, 32'hFFFFFFFF);
        send_glyph(GLYPH_HIGH, 8'd255, 7'd127, 32'hFFFFFFFF, 32'h0);
        send_glyph(GLYPH_HIGH, 8'd40, 7'd15, $urandom(), $urandom());
        send_char(CR_CODE);
        send_char(TAB_CODE);
        send_char(LF_CODE);
        send_char(ESC_CODE);
        send_char(CSI_OPEN);
        send_char(ESC_CODE);
        send_char(DIGIT_ZERO);
        send_char(LOWER_Z_CODE);
        send_char(ESC_CODE);
        send_char(UPPER_Z_CODE);
        send_char(ESC_CODE);
        send_char(UPPER_A_CODE);

        // Smallest screen: every glyph wraps and scrolls; bold colour cases
        apply_setting(12'd8, 9'd1, 8'd1, 1'b1, 32'hFFFFFFFF);
        send_glyph(GLYPH_LOW, 8'd3, 7'd2, 32'hFFFFFFFF, 32'h0);
        send_glyph(GLYPH_HIGH, 8'd0, 7'd127, 32'h12ABFF00, 32'h55AA55AA);
        send_glyph(GLYPH_LOW, 8'd255, 7'd0, 32'h0, 32'hFFFFFFFF);
        send_char(LF_CODE);
        send_char(CR_CODE);
        calm = 1'b1;
        random_burst(10);
        calm = 1'b0;

        // Largest screen: hold the output long so the input backs up
        apply_setting(12'd2048, 9'd256, 8'd128, 1'b0, 32'h0);
        send_char(ESC_CODE);
        send_char(UPPER_A_CODE);
        long_hold_req = 1'b1;
        repeat (4)
            send_glyph(pick_glyph(), 8'($urandom_range(255)), 7'($urandom_range(127)),
                       $urandom(), $urandom());
        random_burst(8);
        repeat (2) send_char(TAB_CODE);
        send_glyph(GLYPH_HIGH, 8'd255, 7'd127, $urandom(), $urandom());

        // Stride above the cap, narrow screen, reset yellow with bold
        apply_setting(12'd4095, 9'd3, 8'd2, 1'b1, YELLOW_COLOR_RST);
        random_burst(8);

        // Random setting
        apply_setting(12'($urandom_range(8, 4095)), 9'($urandom_range(1, 256)),
                      8'($urandom_range(1, 128)), 1'($urandom_range(1)), $urandom());
        random_burst(8);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d glyph draws, %0d scroll-only results, %0d font loads",
                 board.drawn, board.scrolls, board.loads);
        $display("and %0d silent bytes over %0d register settings, with one %0d-cycle hold-off.",
                 board.quiet, settings_used, HOLD_CYCLES);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_front.sv
rtl/tcgr_queue.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer_core.sv
verif/text_console_glyph_renderer_core_tb.sv
